// ===== rtl/core/dpfr_pkg.sv =====
// dpfr_pkg: shared types and constants of the demand page fault resolver.
// Used by dpfr_ctrl, dpfr_datapath and demand_page_fault_resolver.
// No dependencies.
package dpfr_pkg;

  // Fixed field widths
  localparam int TABLE_DEPTH = 8;
  localparam int SLOT_W      = 3;
  localparam int ADDR_W      = 32;
  localparam int ACC_W       = 3;
  localparam int OUTCOME_W   = 3;
  localparam int ZSTART_W    = 16;
  localparam int ZCOUNT_W    = 17;
  localparam int SHIFT_W     = 5;
  localparam int CNT_W       = 4;

  // Mapped-bit memory row layout
  localparam int ROW_W    = 32;
  localparam int BITPOS_W = 5;
  // Page index width at the smallest page size
  localparam int IDX_W    = 20;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

  // Operations (s_axis_tuser)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FAULT = 1'b1;

  // Outcomes (m_axis_tuser)
  localparam logic [OUTCOME_W-1:0] OUT_LOADED   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MAP      = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NOT_IN   = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_MAPPED   = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_BEYOND   = 3'd4;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT  = 2'd1;

  // Stream payload widths
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 104;

  // Controller to datapath
  typedef struct packed {
    logic                 accept;
    logic                 next_slot;
    logic                 page_calc;
    logic                 map_page;
    logic                 zero_calc;
    logic                 clr_step;
    logic                 clr_seg;
    logic                 set_outcome;
    logic [OUTCOME_W-1:0] outcome;
    logic                 out_load;
  } dpfr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_fault;
    logic slot_ok;
    logic search_end;
    logic hit;
    logic beyond;
    logic mapped;
    logic clr_all_last;
    logic clr_seg_last;
  } dpfr_status_t;

endpackage

// ===== rtl/core/dpfr_ctrl.sv =====
// dpfr_ctrl: sequencing state machine and output valid flag of the resolver.
// Depends on dpfr_pkg (command and status types, outcome codes).
module dpfr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dpfr_pkg::dpfr_cmd_t   cmd,
  input  dpfr_pkg::dpfr_status_t status
);

  localparam logic [3:0] ST_CLR_ALL  = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_CLR_SEG  = 4'd3;
  localparam logic [3:0] ST_SEARCH   = 4'd4;
  localparam logic [3:0] ST_PAGE     = 4'd5;
  localparam logic [3:0] ST_READ     = 4'd6;
  localparam logic [3:0] ST_ZERO     = 4'd7;
  localparam logic [3:0] ST_RESULT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLR_ALL: begin
        cmd.clr_step = 1'b1;
        if (status.clr_all_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.is_fault) begin
          state_next = ST_SEARCH;
        end else if (status.slot_ok) begin
          state_next = ST_CLR_SEG;
        end else begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = dpfr_pkg::OUT_LOADED;
          state_next      = ST_RESULT;
        end
      end
      ST_CLR_SEG: begin
        cmd.clr_step = 1'b1;
        cmd.clr_seg  = 1'b1;
        if (status.clr_seg_last) begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = dpfr_pkg::OUT_LOADED;
          state_next      = ST_RESULT;
        end
      end
      ST_SEARCH: begin
        if (status.search_end) begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = dpfr_pkg::OUT_NOT_IN;
          state_next      = ST_RESULT;
        end else if (status.hit) begin
          state_next = ST_PAGE;
        end else begin
          cmd.next_slot = 1'b1;
        end
      end
      ST_PAGE: begin
        if (status.beyond) begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = dpfr_pkg::OUT_BEYOND;
          state_next      = ST_RESULT;
        end else begin
          cmd.page_calc = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        if (status.mapped) begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = dpfr_pkg::OUT_MAPPED;
          state_next      = ST_RESULT;
        end else begin
          cmd.map_page = 1'b1;
          state_next   = ST_ZERO;
        end
      end
      ST_ZERO: begin
        cmd.zero_calc   = 1'b1;
        cmd.set_outcome = 1'b1;
        cmd.outcome     = dpfr_pkg::OUT_MAP;
        state_next      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register holds until taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR_ALL;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/core/dpfr_datapath.sv =====
// dpfr_datapath: configuration registers, segment tables, mapped-bit memory,
// address arithmetic and result registers. Depends on dpfr_pkg.
module dpfr_datapath #(
  parameter int MAX_SEGMENTS      = 8,
  parameter int PAGES_PER_SEGMENT = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [dpfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpfr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_op,
  input  logic [dpfr_pkg::IN_TDATA_W-1:0]    in_data,
  input  dpfr_pkg::dpfr_cmd_t                cmd,
  output dpfr_pkg::dpfr_status_t             status,
  output logic [dpfr_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [dpfr_pkg::OUT_TDATA_W-1:0]   out_data
);

  localparam int NSLOT     = (MAX_SEGMENTS < dpfr_pkg::TABLE_DEPTH) ?
                             MAX_SEGMENTS : dpfr_pkg::TABLE_DEPTH;
  localparam int ROWS      = (PAGES_PER_SEGMENT + dpfr_pkg::ROW_W - 1) / dpfr_pkg::ROW_W;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MEM_AW    = dpfr_pkg::SLOT_W + RW;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam logic [dpfr_pkg::CNT_W-1:0] NSLOT_CNT  = dpfr_pkg::CNT_W'(NSLOT);
  localparam logic [dpfr_pkg::IDX_W-1:0] PAGE_LIMIT = dpfr_pkg::IDX_W'(PAGES_PER_SEGMENT);

  localparam int AW  = dpfr_pkg::ADDR_W;
  localparam int SW  = dpfr_pkg::SLOT_W;

  // Configuration registers
  logic [dpfr_pkg::SHIFT_W-1:0] page_shift;
  logic [dpfr_pkg::CNT_W-1:0]   segment_count;

  // Latched request
  logic                         op_fault;
  logic [SW-1:0]                ld_slot;
  logic [AW-1:0]                fault_addr;
  logic [dpfr_pkg::SHIFT_W-1:0] sh;
  logic [dpfr_pkg::CNT_W-1:0]   cnt;

  // Segment tables
  logic [AW-1:0]              base_tab     [dpfr_pkg::TABLE_DEPTH];
  logic [AW-1:0]              mem_len_tab  [dpfr_pkg::TABLE_DEPTH];
  logic [AW-1:0]              file_len_tab [dpfr_pkg::TABLE_DEPTH];
  logic [AW-1:0]              file_pos_tab [dpfr_pkg::TABLE_DEPTH];
  logic [dpfr_pkg::ACC_W-1:0] acc_tab      [dpfr_pkg::TABLE_DEPTH];

  // Search and page arithmetic
  logic [dpfr_pkg::CNT_W-1:0]    sidx;
  logic [SW-1:0]                 sel;
  logic [AW:0]                   diff;
  logic [AW-1:0]                 off;
  logic [dpfr_pkg::IDX_W-1:0]    pidx;
  logic [AW-1:0]                 page_mask;
  logic [MEM_AW-1:0]             page_addr;
  logic [AW-1:0]                 pstart;
  logic [AW:0]                   pend;
  logic [AW-1:0]                 zs;
  logic                          zero_en;

  // Mapped-bit memory
  logic [dpfr_pkg::ROW_W-1:0]    mem [MEM_DEPTH];
  logic [dpfr_pkg::ROW_W-1:0]    rd_data;
  logic [MEM_AW-1:0]             map_addr;
  logic [dpfr_pkg::BITPOS_W-1:0] bit_pos;
  logic [MEM_AW-1:0]             clr_addr;
  logic [MEM_AW-1:0]             clr_wr_addr;

  // Result and output registers
  logic [dpfr_pkg::OUTCOME_W-1:0] res_outcome;
  logic [AW-1:0]                  res_page_addr;
  logic [AW-1:0]                  res_backing;
  logic [dpfr_pkg::ACC_W-1:0]     res_access;
  logic [dpfr_pkg::ZSTART_W-1:0]  res_zstart;
  logic [dpfr_pkg::ZCOUNT_W-1:0]  res_zcount;
  logic [AW-1:0]                  out_page_addr;
  logic [AW-1:0]                  out_backing;
  logic [dpfr_pkg::ACC_W-1:0]     out_access;
  logic [dpfr_pkg::ZSTART_W-1:0]  out_zstart;
  logic [dpfr_pkg::ZCOUNT_W-1:0]  out_zcount;

  // Input payload fields
  logic [SW-1:0]              in_slot;
  logic [AW-1:0]              in_base;
  logic [AW-1:0]              in_mem_len;
  logic [AW-1:0]              in_file_len;
  logic [AW-1:0]              in_file_pos;
  logic [dpfr_pkg::ACC_W-1:0] in_access;
  logic [AW-1:0]              in_fault;
  logic [dpfr_pkg::SHIFT_W-1:0] sh_clamped;
  logic [dpfr_pkg::CNT_W-1:0]   cnt_clamped;

  assign in_slot     = in_data[2:0];
  assign in_base     = in_data[34:3];
  assign in_mem_len  = in_data[66:35];
  assign in_file_len = in_data[98:67];
  assign in_file_pos = in_data[130:99];
  assign in_access   = in_data[133:131];
  assign in_fault    = in_data[165:134];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift    <= dpfr_pkg::SHIFT_MIN;
      segment_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpfr_pkg::CFG_PAGE_SHIFT: page_shift    <= cfg_data;
        dpfr_pkg::CFG_SEG_COUNT:  segment_count <= cfg_data[dpfr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate configuration into its working range
  always_comb begin
    if (page_shift < dpfr_pkg::SHIFT_MIN)      sh_clamped = dpfr_pkg::SHIFT_MIN;
    else if (page_shift > dpfr_pkg::SHIFT_MAX) sh_clamped = dpfr_pkg::SHIFT_MAX;
    else                                       sh_clamped = page_shift;
    cnt_clamped = (segment_count > NSLOT_CNT) ? NSLOT_CNT : segment_count;
  end

  // Request latch and table write on a load
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_fault   <= (in_op == dpfr_pkg::OP_FAULT);
      ld_slot    <= in_slot;
      fault_addr <= in_fault;
      sh         <= sh_clamped;
      cnt        <= cnt_clamped;
      if (in_op == dpfr_pkg::OP_LOAD && {1'b0, in_slot} < NSLOT_CNT) begin
        base_tab[in_slot]     <= in_base;
        mem_len_tab[in_slot]  <= in_mem_len;
        file_len_tab[in_slot] <= in_file_len;
        file_pos_tab[in_slot] <= in_file_pos;
        acc_tab[in_slot]      <= in_access;
      end
    end
  end

  // Segment match on the current slot
  assign sel  = sidx[SW-1:0];
  assign diff = {1'b0, fault_addr} - {1'b0, base_tab[sel]};

  always_ff @(posedge clk) begin
    if (cmd.accept) sidx <= '0;
    else if (cmd.next_slot) sidx <= sidx + dpfr_pkg::CNT_W'(1);
  end

  // Offset tracks the slot under test; it is stable once a hit stops the search
  always_ff @(posedge clk) begin
    off <= diff[AW-1:0];
  end

  // Page index, memory row and page bounds
  assign pidx      = dpfr_pkg::IDX_W'(off >> sh);
  assign page_mask = {AW{1'b1}} << sh;
  assign page_addr = {sel, pidx[RW+dpfr_pkg::BITPOS_W-1:dpfr_pkg::BITPOS_W]};

  always_ff @(posedge clk) begin
    if (cmd.page_calc) begin
      pstart   <= off & page_mask;
      pend     <= {1'b0, off & page_mask} + ((AW+1)'(1) << sh);
      map_addr <= page_addr;
      bit_pos  <= pidx[dpfr_pkg::BITPOS_W-1:0];
    end
  end

  // Clear pointer: whole memory after reset, one slot's rows on a load
  always_ff @(posedge clk) begin
    if (rst || cmd.accept) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + MEM_AW'(1);
  end

  assign clr_wr_addr = cmd.clr_seg ? {ld_slot, clr_addr[RW-1:0]} : clr_addr;

  // Mapped-bit memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_wr_addr] <= '0;
    else if (cmd.map_page) mem[map_addr] <= rd_data | (dpfr_pkg::ROW_W'(1) << bit_pos);
    if (cmd.page_calc) rd_data <= mem[page_addr];
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_outcome   <= dpfr_pkg::OUT_LOADED;
      res_page_addr <= '0;
      res_backing   <= '0;
      res_access    <= '0;
      res_zstart    <= '0;
      res_zcount    <= '0;
    end else begin
      if (cmd.set_outcome) res_outcome <= cmd.outcome;
      if (cmd.map_page) begin
        res_page_addr <= base_tab[sel] + pstart;
        res_backing   <= file_pos_tab[sel] + pstart;
        res_access    <= acc_tab[sel];
        zero_en       <= mem_len_tab[sel] > file_len_tab[sel];
        zs            <= (file_len_tab[sel] > pstart) ? file_len_tab[sel] : pstart;
      end
      // Zero from the later of page start and file end up to page end
      if (cmd.zero_calc && zero_en && ({1'b0, zs} < pend)) begin
        res_zstart <= dpfr_pkg::ZSTART_W'(zs - pstart);
        res_zcount <= dpfr_pkg::ZCOUNT_W'(pend - {1'b0, zs});
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_outcome   <= res_outcome;
      out_page_addr <= res_page_addr;
      out_backing   <= res_backing;
      out_access    <= res_access;
      out_zstart    <= res_zstart;
      out_zcount    <= res_zcount;
    end
  end

  assign out_data = {4'b0, out_zcount, out_zstart, out_access, out_backing, out_page_addr};

  // Status
  assign status.is_fault     = op_fault;
  assign status.slot_ok      = ({1'b0, ld_slot} < NSLOT_CNT);
  assign status.search_end   = (sidx == cnt);
  assign status.hit          = !diff[AW] && (diff[AW-1:0] < mem_len_tab[sel]);
  assign status.beyond       = (pidx >= PAGE_LIMIT);
  assign status.mapped       = rd_data[bit_pos];
  assign status.clr_all_last = &clr_addr;
  assign status.clr_seg_last = &clr_addr[RW-1:0];

endmodule

// ===== rtl/core/demand_page_fault_resolver.sv =====
// Demand page fault resolver: one request is in flight at a time and each
// request gives one result. A load into a slot below MAX_SEGMENTS clears the
// slot's R rows of the mapped-bit memory, one row a cycle, R being
// ceil(PAGES_PER_SEGMENT / 32) rounded up to a power of two of at least 2
// (8 by default); a load into a slot at or above MAX_SEGMENTS skips the
// clear. A fault compares one slot per cycle until a segment matches or the
// searched slots run out; on a match it checks the page against capacity,
// reads the bitmap, and for an unmapped page writes the bitmap and then
// computes the zero range. A stalled output holds the finished result in the
// controller until the output register is free.
// After reset the block clears the whole mapped-bit memory, 8 * R rows
// (64 by default), and holds s_axis_tready low until then; configuration
// writes are taken at any time and apply from the next accepted request. The
// result waits in an output register while the next request is accepted.
// Depends on dpfr_pkg, dpfr_ctrl and dpfr_datapath.
module demand_page_fault_resolver #(
  parameter int MAX_SEGMENTS      = 8,
  parameter int PAGES_PER_SEGMENT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpfr_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // seg_slot[2:0], seg_base[34:3], seg_mem_len[66:35], seg_file_len[98:67],
  // seg_file_pos[130:99], seg_access[133:131], fault_address[165:134]
  input  logic [dpfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation[0]
  input  logic                                s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // page_address[31:0], backing_offset[63:32], page_access[66:64],
  // zero_start[82:67], zero_count[99:83]
  output logic [dpfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // outcome[2:0]
  output logic [dpfr_pkg::OUTCOME_W-1:0]      m_axis_tuser
);

  dpfr_pkg::dpfr_cmd_t    cmd;
  dpfr_pkg::dpfr_status_t status;

  assign cfg_ready = 1'b1;

  dpfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  dpfr_datapath #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .PAGES_PER_SEGMENT (PAGES_PER_SEGMENT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_op       (s_axis_tuser),
    .in_data     (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_outcome (m_axis_tuser),
    .out_data    (m_axis_tdata)
  );

  // One request in flight: acceptance drops ready for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // Only a map outcome carries payload
  a_clean_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != dpfr_pkg::OUT_MAP) |-> (m_axis_tdata == '0))
    else $error("non-map result with nonzero payload");

  // Empty zero range starts at zero
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[99:83] == '0) |-> (m_axis_tdata[82:67] == '0))
    else $error("zero_start set with empty zero range");

  // Result is only loaded on a finished request with the output free
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten while held");

endmodule
